// ----- hw/rtl/spc_pkg.sv -----
// ============================================================================
// spc_pkg - shared types and constants
// Widths, request codes, sequencer states and cell control for the sliding
// correlation core.
// ============================================================================
`default_nettype none

package spc_pkg;

    localparam int MAX_TAPS    = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(MAX_TAPS);
    localparam int CNT_W       = $clog2(MAX_TAPS + 1);
    localparam int LEN_W       = 6;
    localparam int REQ_W       = 2;
    localparam int SUM_W       = SAMPLE_BITS + IDX_W + 1;
    localparam int ACC_W       = 2 * SAMPLE_BITS + IDX_W;
    localparam int WIDE_W      = 2 * SUM_W + 2;
    localparam int CHUNK_W     = 16;
    localparam int N_CHUNK     = (WIDE_W + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W       = N_CHUNK * CHUNK_W;
    localparam int PROD_W      = 2 * WIDE_W;
    localparam int Q_W         = 15;
    localparam int OUT_W       = Q_W + 1;
    localparam int FRAC_SHIFT  = 2 * Q_W;
    localparam int ROOT_W      = PROD_W + FRAC_SHIFT + 2;
    localparam int LAST_STEP   = N_CHUNK + Q_W;
    localparam int STEP_W      = $clog2(LAST_STEP + 1);
    localparam int SEEN_W      = 16;

    localparam logic [REQ_W-1:0] REQ_TAP     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_PROD,
        ST_DIFF,
        ST_RATIO,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic push;
        logic load;
        logic step_x;
        logic step_h;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sliding_pearson_correlation_core.sv -----
// ============================================================================
// sliding_pearson_correlation_core - sliding normalized cross-correlation
// Scores each full window of the signal against a loaded template with the
// Pearson coefficient, Q1.15, truncated and saturated.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries requests: write a template
//   tap, push a signal sample, or restart the window fill. cfg_we writes the
//   template length (clamped to 2..32) and restarts the fill.
//   Output channel (out_valid / out_stall) carries one result per signal
//   sample once the window has filled to the template length since the last
//   restart. Tap writes, restarts and filling samples never raise in_stall.
//   A scoring sample goes through these steps on its way to the result
//   register: a load step, a walk of the cell chain (one multiply-accumulate
//   of tap and sample per cycle at the active positions), the product and
//   difference states, then the ratio unit: chunked-multiply steps, one setup
//   and 15 one-bit steps, the sequencer seeing it finish, and the result load.
//   A zero variance skips the ratio unit. in_stall is high during that span.
//   The result waits in an output register; a new request is taken while it
//   waits, and the next result holds in the sequencer until it is taken.
//   Reset clears the fill count, sample counter, length (to 32) and the
//   output valid flag; template taps are undefined until written.
// ============================================================================
`default_nettype none

module sliding_pearson_correlation_core
    import spc_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [LEN_W-1:0]              cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [REQ_W-1:0]              req_type,
    input  wire logic [IDX_W-1:0]              tap_index,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [OUT_W-1:0]            coeff,
    output logic                               zero_variance,
    output logic [SEEN_W-1:0]                  window_start
);

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  fill_reg, fill_next, fill_inc;
    logic [SEEN_W-1:0] seen_reg, seen_next, seen_inc;
    logic [IDX_W-1:0]  walk_reg, walk_next;
    logic              out_valid_reg, out_valid_next;

    logic                          accept;
    logic                          take_sample;
    logic                          out_load;
    logic                          active;
    cell_ctl_t                     ctl;
    logic [MAX_TAPS-1:0]           tap_we;
    logic signed [SAMPLE_BITS-1:0] win_out [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] wx_out  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] wh_out  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] xv, hv;
    logic signed [2*SAMPLE_BITS-1:0] hx, hh, xx;

    logic signed [SUM_W-1:0]  sh_reg, sx_reg;
    logic signed [ACC_W-1:0]  shh_reg, shx_reg, sxx_reg;
    logic signed [WIDE_W-1:0] a1_reg, a2_reg, b1_reg, b2_reg, c1_reg, c2_reg;
    logic signed [WIDE_W-1:0] n_w, num, va, vb, mag;
    logic                     zv_now, neg_now, zv_reg, neg_reg;
    logic                     root_start, root_done;
    logic [Q_W-1:0]           root_q;
    logic [SEEN_W-1:0]        wstart_reg;
    logic signed [OUT_W-1:0]  coeff_reg;
    logic                     zero_reg;
    logic [SEEN_W-1:0]        window_start_reg;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign take_sample = accept && (req_type == REQ_SAMPLE);
    assign fill_inc    = (fill_reg == CNT_W'(MAX_TAPS)) ? fill_reg : fill_reg + 1'b1;
    assign seen_inc    = seen_reg + 1'b1;
    assign active      = CNT_W'(walk_reg) >= (CNT_W'(MAX_TAPS) - CNT_W'(n_reg));
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_sample && (fill_inc >= CNT_W'(n_reg)))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_reg == IDX_W'(MAX_TAPS - 1))
                begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = zv_now ? ST_DONE : ST_RATIO;
            end
            ST_RATIO:
            begin
                if (root_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl        = '0;
        walk_next  = '0;
        root_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.push = take_sample;
            end
            ST_LOAD:
            begin
                ctl.load = 1'b1;
            end
            ST_WALK:
            begin
                ctl.step_x = 1'b1;
                ctl.step_h = active;
                walk_next  = walk_reg + 1'b1;
            end
            ST_DIFF:
            begin
                root_start = !zv_now;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_comb
    begin
        n_next    = n_reg;
        fill_next = fill_reg;
        seen_next = seen_reg;
        if (cfg_we)
        begin
            if (cfg_data < LEN_W'(2))
            begin
                n_next = LEN_W'(2);
            end
            else if (cfg_data > LEN_W'(MAX_TAPS))
            begin
                n_next = LEN_W'(MAX_TAPS);
            end
            else
            begin
                n_next = cfg_data;
            end
            fill_next = '0;
            seen_next = '0;
        end
        else if (accept && (req_type == REQ_RESTART))
        begin
            fill_next = '0;
            seen_next = '0;
        end
        else if (take_sample)
        begin
            fill_next = fill_inc;
            seen_next = seen_inc;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= LEN_W'(MAX_TAPS);
            fill_reg      <= '0;
            seen_reg      <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            fill_reg      <= fill_next;
            seen_reg      <= seen_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TAPS; gi++)
        begin : g_cell
            logic signed [SAMPLE_BITS-1:0] win_in, wx_in, wh_in;

            assign tap_we[gi] = accept && (req_type == REQ_TAP)
                                && (tap_index == IDX_W'(gi));

            if (gi == 0)
            begin : g_head
                assign win_in = sample;
                assign wx_in  = '0;
            end
            else
            begin : g_body
                assign win_in = win_out[gi-1];
                assign wx_in  = wx_out[gi-1];
            end

            if (gi == MAX_TAPS - 1)
            begin : g_tail
                assign wh_in = '0;
            end
            else
            begin : g_inner
                assign wh_in = wh_out[gi+1];
            end

            spc_cell u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .tap_we  (tap_we[gi]),
                .tap_val (sample),
                .win_in  (win_in),
                .wx_in   (wx_in),
                .wh_in   (wh_in),
                .win_out (win_out[gi]),
                .wx_out  (wx_out[gi]),
                .wh_out  (wh_out[gi])
            );
        end
    endgenerate

    assign xv = wx_out[MAX_TAPS-1];
    assign hv = wh_out[0];
    assign hx = hv * xv;
    assign hh = hv * hv;
    assign xx = xv * xv;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            sh_reg  <= '0;
            sx_reg  <= '0;
            shh_reg <= '0;
            shx_reg <= '0;
            sxx_reg <= '0;
        end
        else if ((state_reg == ST_WALK) && active)
        begin
            sh_reg  <= sh_reg + SUM_W'(hv);
            sx_reg  <= sx_reg + SUM_W'(xv);
            shh_reg <= shh_reg + ACC_W'(hh);
            shx_reg <= shx_reg + ACC_W'(hx);
            sxx_reg <= sxx_reg + ACC_W'(xx);
        end
    end

    assign n_w = WIDE_W'(signed'({1'b0, n_reg}));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PROD)
        begin
            a1_reg <= n_w * WIDE_W'(shx_reg);
            a2_reg <= WIDE_W'(sh_reg) * WIDE_W'(sx_reg);
            b1_reg <= n_w * WIDE_W'(shh_reg);
            b2_reg <= WIDE_W'(sh_reg) * WIDE_W'(sh_reg);
            c1_reg <= n_w * WIDE_W'(sxx_reg);
            c2_reg <= WIDE_W'(sx_reg) * WIDE_W'(sx_reg);
        end
    end

    assign num     = a1_reg - a2_reg;
    assign va      = b1_reg - b2_reg;
    assign vb      = c1_reg - c2_reg;
    assign zv_now  = (va == '0) || (vb == '0);
    assign neg_now = num[WIDE_W-1];
    assign mag     = neg_now ? -num : num;

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            wstart_reg <= seen_inc - SEEN_W'(n_reg);
        end
        if (state_reg == ST_DIFF)
        begin
            zv_reg  <= zv_now;
            neg_reg <= neg_now;
        end
        if (out_load)
        begin
            window_start_reg <= wstart_reg;
            zero_reg         <= zv_reg;
            if (zv_reg)
            begin
                coeff_reg <= '0;
            end
            else if (neg_reg)
            begin
                coeff_reg <= -signed'({1'b0, root_q});
            end
            else
            begin
                coeff_reg <= signed'({1'b0, root_q});
            end
        end
    end

    spc_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .va    ($unsigned(va)),
        .vb    ($unsigned(vb)),
        .mag   ($unsigned(mag)),
        .done  (root_done),
        .q     (root_q)
    );

    assign out_valid     = out_valid_reg;
    assign coeff         = coeff_reg;
    assign zero_variance = zero_reg;
    assign window_start  = window_start_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/spc_cell.sv -----
// ============================================================================
// spc_cell - one position of the window and template chain
// Holds one window sample and one template tap, plus work copies of both
// that shift to the neighbors during the multiply-accumulate walk.
// ============================================================================
`default_nettype none

module spc_cell
    import spc_pkg::*;
(
    input  wire logic                          clk,
    input  wire cell_ctl_t                     ctl,
    input  wire logic                          tap_we,
    input  wire logic signed [SAMPLE_BITS-1:0] tap_val,
    input  wire logic signed [SAMPLE_BITS-1:0] win_in,
    input  wire logic signed [SAMPLE_BITS-1:0] wx_in,
    input  wire logic signed [SAMPLE_BITS-1:0] wh_in,
    output logic signed [SAMPLE_BITS-1:0]      win_out,
    output logic signed [SAMPLE_BITS-1:0]      wx_out,
    output logic signed [SAMPLE_BITS-1:0]      wh_out
);

    logic signed [SAMPLE_BITS-1:0] win_reg;
    logic signed [SAMPLE_BITS-1:0] tap_reg;
    logic signed [SAMPLE_BITS-1:0] wx_reg;
    logic signed [SAMPLE_BITS-1:0] wh_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            win_reg <= win_in;
        end
        if (tap_we)
        begin
            tap_reg <= tap_val;
        end
        if (ctl.load)
        begin
            wx_reg <= win_reg;
            wh_reg <= tap_reg;
        end
        else
        begin
            if (ctl.step_x)
            begin
                wx_reg <= wx_in;
            end
            if (ctl.step_h)
            begin
                wh_reg <= wh_in;
            end
        end
    end

    assign win_out = win_reg;
    assign wx_out  = wx_reg;
    assign wh_out  = wh_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/spc_root.sv -----
// ============================================================================
// spc_root - iterative ratio unit
// Forms both variance product and squared numerator by chunked multiply,
// then finds the largest q with q^2 * va * vb <= num^2 * 2^30, one bit a
// cycle, with running scaled terms instead of trial multiplies.
// ============================================================================
`default_nettype none

module spc_root
    import spc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WIDE_W-1:0] va,
    input  wire logic [WIDE_W-1:0] vb,
    input  wire logic [WIDE_W-1:0] mag,
    output logic                   done,
    output logic [Q_W-1:0]         q
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [WIDE_W-1:0] va_reg;
    logic [WIDE_W-1:0] mag_reg;
    logic [PAD_W-1:0]  vb_reg;
    logic [PAD_W-1:0]  mb_reg;
    logic [PROD_W-1:0] p_reg;
    logic [PROD_W-1:0] l_reg;
    logic [ROOT_W-1:0] y_reg;
    logic [ROOT_W-1:0] zs_reg;
    logic [ROOT_W-1:0] ps_reg;
    logic [Q_W-1:0]    q_reg;
    logic [ROOT_W-1:0] d;
    logic              fit;
    logic [WIDE_W+CHUNK_W-1:0] pp_vb;
    logic [WIDE_W+CHUNK_W-1:0] pp_mb;

    assign d     = zs_reg + ps_reg;
    assign fit   = (d <= y_reg);
    assign pp_vb = va_reg * vb_reg[PAD_W-1 -: CHUNK_W];
    assign pp_mb = mag_reg * mb_reg[PAD_W-1 -: CHUNK_W];

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(LAST_STEP))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            va_reg  <= va;
            mag_reg <= mag;
            vb_reg  <= PAD_W'(vb);
            mb_reg  <= PAD_W'(mag);
            p_reg   <= '0;
            l_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg < STEP_W'(N_CHUNK))
            begin
                p_reg  <= (p_reg << CHUNK_W) + PROD_W'(pp_vb);
                l_reg  <= (l_reg << CHUNK_W) + PROD_W'(pp_mb);
                vb_reg <= vb_reg << CHUNK_W;
                mb_reg <= mb_reg << CHUNK_W;
            end
            else if (step_reg == STEP_W'(N_CHUNK))
            begin
                y_reg  <= ROOT_W'(l_reg) << FRAC_SHIFT;
                ps_reg <= ROOT_W'(p_reg) << (2 * (Q_W - 1));
                zs_reg <= '0;
                q_reg  <= '0;
            end
            else
            begin
                if (fit)
                begin
                    y_reg  <= y_reg - d;
                    zs_reg <= (zs_reg + (ps_reg << 1)) >> 1;
                end
                else
                begin
                    zs_reg <= zs_reg >> 1;
                end
                ps_reg <= ps_reg >> 2;
                q_reg  <= {q_reg[Q_W-2:0], fit};
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/spc_check.sv -----
// ============================================================================
// spc_check - port checker for the sliding correlation core
// Watches the output channel for held requests and legal result values.
// ============================================================================
`default_nettype none

module spc_check
    import spc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic signed [OUT_W-1:0] coeff,
    input wire logic                   zero_variance
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output request dropped while stalled");

    a_coeff_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(coeff))
        else $error("coeff changed while stalled");

    a_zero_coeff: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_variance |-> coeff == '0)
        else $error("zero variance with nonzero coeff");

    a_coeff_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> coeff != {1'b1, {(OUT_W-1){1'b0}}})
        else $error("coeff outside saturation range");

endmodule

bind sliding_pearson_correlation_core spc_check u_spc_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .coeff         (coeff),
    .zero_variance (zero_variance)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - sliding Pearson correlation core testbench
// Drives template writes, signal samples, restarts and length changes into the
// core, predicts each Q1.15 coefficient exactly in integers, and compares every
// result in order against the prediction under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top
    import spc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic signed [OUT_W-1:0] coeff;
        logic                    zero_variance;
        logic [SEEN_W-1:0]       window_start;
    } score_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [LEN_W-1:0]              cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [REQ_W-1:0]              req_type;
    logic [IDX_W-1:0]              tap_index;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [OUT_W-1:0]       coeff;
    logic                          zero_variance;
    logic [SEEN_W-1:0]             window_start;

    sliding_pearson_correlation_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
        .tap_index(tap_index), .sample(sample), .out_valid(out_valid),
        .out_stall(out_stall), .coeff(coeff), .zero_variance(zero_variance),
        .window_start(window_start)
    );

    // predictor state
    logic signed [SAMPLE_BITS-1:0] tmpl_taps [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] sig_window [MAX_TAPS];
    int unsigned                   win_len;
    int unsigned                   wr_ptr;
    int unsigned                   filled;
    logic [SEEN_W-1:0]             seen_count;

    score_t      expected_scores [$];
    int unsigned mismatches;
    int unsigned hold_off;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void clear_fill();
        wr_ptr = 0;
        filled = 0;
        seen_count = '0;
    endfunction

    function automatic void score_window();
        longint sh, shh, shx, sx, sxx, num, va, vb, h, x;
        logic [159:0] mag, lim, prod, t;
        int unsigned pos, q;
        score_t e;
        sh = 0; shh = 0; shx = 0; sx = 0; sxx = 0;
        for (int k = 0; k < win_len; k++)
        begin
            pos = (wr_ptr + MAX_TAPS - win_len + k) % MAX_TAPS;
            h = tmpl_taps[k];
            x = sig_window[pos];
            sh += h; shh += h * h; shx += h * x; sx += x; sxx += x * x;
        end
        num = longint'(win_len) * shx - sh * sx;
        va = longint'(win_len) * shh - sh * sh;
        vb = longint'(win_len) * sxx - sx * sx;
        e.window_start = seen_count - SEEN_W'(win_len);
        if (va == 0 || vb == 0)
        begin
            e.coeff = '0;
            e.zero_variance = 1'b1;
        end
        else
        begin
            mag = (num < 0) ? 160'(-num) : 160'(num);
            lim = (mag * mag) << 30;
            prod = 160'(va) * 160'(vb);
            q = 0;
            for (int b = 14; b >= 0; b--)
            begin
                t = q | (1 << b);
                if (t * t * prod <= lim)
                    q = t;
            end
            e.coeff = (num < 0) ? -OUT_W'(q) : OUT_W'(q);
            e.zero_variance = 1'b0;
        end
        expected_scores.push_back(e);
    endfunction

    function automatic void predict_request(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx,
                                            logic signed [SAMPLE_BITS-1:0] value);
        if (kind == REQ_TAP)
            tmpl_taps[idx] = value;
        else if (kind == REQ_RESTART)
            clear_fill();
        else if (kind == REQ_SAMPLE)
        begin
            sig_window[wr_ptr] = value;
            wr_ptr = (wr_ptr + 1) % MAX_TAPS;
            if (filled < MAX_TAPS)
                filled++;
            seen_count++;
            if (filled >= win_len)
                score_window();
        end
    endfunction

    task automatic send_request(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx,
                                logic signed [SAMPLE_BITS-1:0] value);
        int unsigned r, gap;
        r = $urandom_range(99);
        gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        tap_index <= idx;
        sample    <= value;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(kind, idx, value);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_length(logic [LEN_W-1:0] len);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        win_len = (len < 2) ? 2 : (len > MAX_TAPS) ? MAX_TAPS : len;
        clear_fill();
    endtask

    task automatic send_samples(int count);
        for (int i = 0; i < count; i++)
            send_request(REQ_SAMPLE, IDX_W'($urandom), SAMPLE_BITS'($urandom));
    endtask

    task automatic test_template_load();
        for (int i = 0; i < MAX_TAPS; i++)
            send_request(REQ_TAP, IDX_W'(i), SAMPLE_BITS'($urandom));
        send_samples(MAX_TAPS + 3);
    endtask

    task automatic test_perfect_correlation();
        set_length(4);
        for (int i = 0; i < 4; i++)
            send_request(REQ_TAP, IDX_W'(i), SAMPLE_BITS'(i * 1000 - 1500));
        for (int i = 0; i < 4; i++)
            send_request(REQ_SAMPLE, '0, SAMPLE_BITS'(i * 1000 - 1500));
        for (int i = 0; i < 4; i++)
            send_request(REQ_SAMPLE, '0, SAMPLE_BITS'(1500 - i * 1000));
    endtask

    task automatic test_zero_variance_and_extremes();
        set_length(0);
        send_request(REQ_SAMPLE, '0, 16'sh7fff);
        send_request(REQ_SAMPLE, '0, 16'sh7fff);
        send_request(REQ_SAMPLE, '0, -16'sh8000);
        send_request(REQ_TAP, 5'd31, -16'sh8000);
        send_request(REQ_UNUSED, 5'd31, 16'sh1234);
        send_request(REQ_RESTART, '0, '0);
        send_request(REQ_SAMPLE, '0, -16'sh8000);
        send_request(REQ_TAP, 5'd1, 16'sh0000);
        send_request(REQ_TAP, 5'd0, 16'sh0000);
        send_request(REQ_SAMPLE, '0, 16'sh7fff);
        send_request(REQ_TAP, 5'd0, 16'sh7fff);
    endtask

    task automatic test_backpressure();
        set_length(2);
        hold_off = 400;
        send_samples(12);
        drain();
    endtask

    task automatic test_random_traffic(int total);
        logic [LEN_W-1:0] lens [11] = '{LEN_W'(0), LEN_W'(1), LEN_W'(2), LEN_W'(3),
                                        LEN_W'(5), LEN_W'(8), LEN_W'(16), LEN_W'(31),
                                        LEN_W'(32), LEN_W'(33), LEN_W'(63)};
        int unsigned r, mode;
        logic signed [SAMPLE_BITS-1:0] v;
        int sent;
        sent = 0;
        while (sent < total)
        begin
            set_length(($urandom_range(3) == 0) ? LEN_W'($urandom)
                                                : lens[$urandom_range($size(lens) - 1)]);
            mode = $urandom_range(3);
            for (int i = 0; i < 60 && sent < total; i++)
            begin
                r = $urandom_range(99);
                case (mode)
                    0: v = SAMPLE_BITS'($urandom);
                    1: v = SAMPLE_BITS'(int'($urandom_range(8)) - 4);
                    2: v = ($urandom_range(3) == 0) ? SAMPLE_BITS'($urandom) : 16'sd7;
                    default: v = $urandom_range(1) ? 16'sh7fff : -16'sh8000;
                endcase
                if (r < 84)
                    send_request(REQ_SAMPLE, IDX_W'($urandom), v);
                else if (r < 92)
                    send_request(REQ_TAP, IDX_W'($urandom), SAMPLE_BITS'($urandom));
                else if (r < 96)
                    send_request(REQ_RESTART, IDX_W'($urandom), SAMPLE_BITS'($urandom));
                else
                    send_request(REQ_UNUSED, IDX_W'($urandom), SAMPLE_BITS'($urandom));
                sent++;
            end
        end
    endtask

    // result checker and receiver stall
    initial begin
        int unsigned r;
        score_t e;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_scores.size() == 0)
                begin
                    $display("%0t: unexpected result coeff=%0d zv=%0b start=%0d",
                             $time, coeff, zero_variance, window_start);
                    mismatches++;
                end
                else
                begin
                    e = expected_scores.pop_front();
                    if (coeff !== e.coeff || zero_variance !== e.zero_variance ||
                        window_start !== e.window_start)
                    begin
                        $display("%0t: expected coeff=%0d zv=%0b start=%0d, got %0d %0b %0d",
                                 $time, e.coeff, e.zero_variance, e.window_start,
                                 coeff, zero_variance, window_start);
                        mismatches++;
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_stall <= 1'b1;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 60)
                    out_stall <= 1'b0;
                else if (r < 96)
                    out_stall <= 1'b1;
                else
                begin
                    hold_off = $urandom_range(5, 30);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        hold_off = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_TAP;
        tap_index = '0;
        sample = '0;
        win_len = MAX_TAPS;
        clear_fill();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_template_load();
        test_perfect_correlation();
        test_zero_variance_and_extremes();
        test_backpressure();
        test_random_traffic(1400);
        set_length(32);
        send_samples(40);
        drain();
        if (mismatches == 0 && expected_scores.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
